### src/dweb_pkg.sv
// ----------------------------------------------------------------------------
// dweb_pkg: shared types and constants for the DAQ word event assembler
// Word operation codes, queue entry, configuration and result records.
// ----------------------------------------------------------------------------
package dweb_pkg;

    // terminator patterns (either 32-bit half)
    localparam logic [31:0] TERM_A = 32'h5E5E_5E5E;
    localparam logic [31:0] TERM_B = 32'hFFFF_FFFF;

    // overflow codes of the charges
    localparam logic [15:0] LONG_OVF  = 16'hFFFF;
    localparam logic [14:0] SHORT_OVF = 15'h7FFF;

    // word types, bits 63:62
    localparam logic [1:0] TYPE_ADC   = 2'd3;
    localparam logic [1:0] TYPE_INFO  = 2'd2;
    localparam logic [1:0] TYPE_TRACE = 2'd1;

    // ADC item kinds, bits 55:54
    localparam logic [1:0] DID_LONG  = 2'd0;
    localparam logic [1:0] DID_SHORT = 2'd1;
    localparam logic [1:0] DID_BASE  = 2'd2;
    localparam logic [1:0] DID_FINE  = 2'd3;

    // event flag bits
    localparam int FLAG_LONG  = 0;
    localparam int FLAG_SHORT = 1;
    localparam int FLAG_BASE  = 2;
    localparam int FLAG_FINE  = 3;
    localparam int FLAG_TRACE = 4;
    localparam int FLAG_W     = 5;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODULE_COUNT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_TS_CODE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_CODE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PSD_MODE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TS_SCALE      = 3'd5;

    // queue between decoder and assembler
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int TDATA_W = 184;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_SAMPLE = 3'd1,
        OP_INFO   = 3'd2,
        OP_SYNC   = 3'd3,
        OP_ADC    = 3'd4,
        OP_TRACE  = 3'd5,
        OP_FINISH = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        KIND_EVENT = 2'd0,
        KIND_INFO  = 2'd1,
        KIND_TRACE = 2'd2,
        KIND_DROP  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [5:0] module_count;
        logic [6:0] channel_count;
        logic [3:0] high_ts_code;
        logic [3:0] sync_code;
        logic       psd_mode;
        logic [7:0] ts_scale;
    } t_cfg;

    // stamp: scaled ADC/trace time, or assembled sync time
    typedef struct packed {
        t_op         op;
        logic [63:0] word;
        logic [63:0] stamp;
    } t_entry;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  module_res;
        logic [5:0]  channel;
        logic [63:0] timestamp;
        logic [15:0] long_charge;
        logic [14:0] short_charge;
        logic [15:0] aux_value;
        logic        aux_is_fine;
        logic [13:0] sample_a;
        logic [13:0] sample_b;
        logic [13:0] sample_c;
        logic [13:0] sample_d;
    } t_result;

endpackage

### src/dweb_front.sv
// ----------------------------------------------------------------------------
// dweb_front: word decoder
// Classifies each word, tracks the timestamp upper bits and the pending
// trace sample count, and scales ADC/trace times.
// ----------------------------------------------------------------------------
module dweb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dweb_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [63:0]       i_word,
    output logic              o_push,
    output dweb_pkg::t_entry  o_entry,
    input  logic              i_full
);
    import dweb_pkg::*;

    logic [13:0] r_samples_left, n_samples_left;
    logic [19:0] r_ts_middle, n_ts_middle;
    logic [15:0] r_ts_high, n_ts_high;

    logic [31:0] hi, lo;
    logic        accept, term, id_ok;
    logic [55:0] scaled;
    t_op         op;
    logic [63:0] stamp;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign hi      = i_word[63:32];
    assign lo      = i_word[31:0];
    assign term    = (hi == TERM_A) || (hi == TERM_B) || (lo == TERM_A) || (lo == TERM_B);
    assign id_ok   = ({1'b0, hi[28:24]} < i_cfg.module_count)
                  && ({1'b0, hi[21:16]} < i_cfg.channel_count);
    assign scaled  = 56'({r_ts_middle, lo[27:0]}) * 56'(i_cfg.ts_scale);

    always_comb begin
        n_samples_left = r_samples_left;
        n_ts_middle    = r_ts_middle;
        n_ts_high      = r_ts_high;
        op             = OP_NONE;
        stamp          = {8'd0, scaled};
        priority if (term) begin
            n_samples_left = '0;
        end else if (r_samples_left != '0) begin
            n_samples_left = r_samples_left - 14'd1;
            op             = OP_SAMPLE;
        end else begin
            unique case (hi[31:30])
                TYPE_ADC: begin
                    op = id_ok ? OP_ADC : OP_FINISH;
                end
                TYPE_INFO: begin
                    // high code has priority over sync code
                    priority if (hi[23:20] == i_cfg.high_ts_code) begin
                        n_ts_high = hi[15:0];
                    end else if (hi[23:20] == i_cfg.sync_code) begin
                        n_ts_middle = hi[19:0];
                        op          = OP_SYNC;
                        stamp       = {r_ts_high, hi[19:0], lo[27:0]};
                    end else begin
                        op = OP_INFO;
                    end
                end
                TYPE_TRACE: begin
                    if (id_ok) begin
                        n_samples_left = hi[15:2];
                        op             = OP_TRACE;
                    end else begin
                        op = OP_FINISH;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_push        = accept && (op != OP_NONE);
    assign o_entry.op    = op;
    assign o_entry.word  = i_word;
    assign o_entry.stamp = stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_left <= '0;
            r_ts_middle    <= '0;
            r_ts_high      <= '0;
        end else if (accept) begin
            r_samples_left <= n_samples_left;
            r_ts_middle    <= n_ts_middle;
            r_ts_high      <= n_ts_high;
        end
    end

endmodule

### src/dweb_queue.sv
// ----------------------------------------------------------------------------
// dweb_queue: short FIFO of decoded words
// Register-based, lets decoder and assembler stall independently.
// ----------------------------------------------------------------------------
module dweb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dweb_pkg::t_entry  i_entry,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output dweb_pkg::t_entry  o_entry
);
    import dweb_pkg::*;

    t_entry             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/dweb_back.sv
// ----------------------------------------------------------------------------
// dweb_back: event assembler
// Holds the event under construction and the last timestamp, runs the
// completion/drop check, and drives the registered result slot.
// ----------------------------------------------------------------------------
module dweb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psd_mode,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  dweb_pkg::t_entry   i_entry,
    output logic               o_valid,
    input  logic               i_ready,
    output dweb_pkg::t_result  o_result
);
    import dweb_pkg::*;

    logic [FLAG_W-1:0] r_have, n_have;
    logic [4:0]        r_ev_mod, n_ev_mod;
    logic [5:0]        r_ev_ch, n_ev_ch;
    logic [63:0]       r_ev_time, n_ev_time;
    logic [15:0]       r_ev_long, n_ev_long;
    logic [14:0]       r_ev_short, n_ev_short;
    logic [15:0]       r_ev_aux, n_ev_aux;
    logic              r_ev_fine, n_ev_fine;
    logic [63:0]       r_last, n_last;

    logic              r_out_valid;
    t_result           r_out;

    logic              can_go, pop, emit, fin, check, done, drop, dup;
    logic [15:0]       adc;
    logic [1:0]        did;
    logic [63:0]       w;
    t_result           rec;

    function automatic t_result event_rec(t_kind kind, logic [4:0] m, logic [5:0] c,
                                          logic [63:0] t, logic [15:0] lc,
                                          logic [14:0] sc, logic [15:0] aux,
                                          logic fine);
        t_result r;
        r              = '0;
        r.kind         = kind;
        r.module_res   = {1'b0, m};
        r.channel      = c;
        r.timestamp    = t;
        r.long_charge  = lc;
        r.short_charge = sc;
        r.aux_value    = aux;
        r.aux_is_fine  = fine;
        return r;
    endfunction

    assign can_go  = !r_out_valid || i_ready;
    assign pop     = i_q_valid && can_go;
    assign o_q_pop = pop;
    assign w       = i_entry.word;
    assign adc     = w[47:32];
    assign did     = w[55:54];

    always_comb begin
        n_have     = r_have;
        n_ev_mod   = r_ev_mod;
        n_ev_ch    = r_ev_ch;
        n_ev_time  = r_ev_time;
        n_ev_long  = r_ev_long;
        n_ev_short = r_ev_short;
        n_ev_aux   = r_ev_aux;
        n_ev_fine  = r_ev_fine;
        n_last     = r_last;
        emit       = 1'b0;
        fin        = 1'b0;
        check      = 1'b0;
        done       = 1'b0;
        drop       = 1'b0;
        dup        = 1'b0;
        rec        = '0;
        unique case (i_entry.op)
            OP_SAMPLE: begin
                emit          = 1'b1;
                rec.kind      = KIND_TRACE;
                rec.module_res = {1'b0, r_ev_mod};
                rec.channel   = r_ev_ch;
                rec.timestamp = r_ev_time;
                rec.sample_a  = w[45:32];
                rec.sample_b  = w[61:48];
                rec.sample_c  = w[13:0];
                rec.sample_d  = w[29:16];
            end
            OP_INFO: begin
                emit           = 1'b1;
                rec.kind       = KIND_INFO;
                rec.module_res = w[61:56];
                rec.timestamp  = r_last;
                rec.aux_value  = {12'd0, w[55:52]};
            end
            OP_SYNC: begin
                n_last = i_entry.stamp;
            end
            OP_ADC: begin
                n_last = i_entry.stamp;
                // an ADC word on top of a held long charge may close the event
                if (r_have[FLAG_LONG]) begin
                    fin = i_psd_mode ? (r_have[FLAG_SHORT]
                                        && (r_have[FLAG_BASE] || r_have[FLAG_FINE]))
                                     : 1'b1;
                end
                if (fin) begin
                    emit       = 1'b1;
                    rec        = event_rec(KIND_EVENT, r_ev_mod, r_ev_ch, r_ev_time,
                                           r_ev_long, r_ev_short, r_ev_aux, r_ev_fine);
                    n_have     = '0;
                    n_ev_long  = '0;
                    n_ev_short = '0;
                    n_ev_aux   = '0;
                    n_ev_fine  = 1'b0;
                end
                if ((r_have == '0) || fin) begin
                    n_ev_time = i_entry.stamp;
                    n_ev_mod  = w[60:56];
                    n_ev_ch   = w[53:48];
                end
                // duplicates of a held item are dropped
                unique case (did)
                    DID_LONG: begin
                        dup = n_have[FLAG_LONG];
                        if (!dup) begin
                            n_ev_long         = (adc == LONG_OVF) ? '0 : adc;
                            n_have[FLAG_LONG] = 1'b1;
                        end
                    end
                    DID_SHORT: begin
                        dup = n_have[FLAG_SHORT];
                        if (!dup) begin
                            n_ev_short         = (adc[14:0] == SHORT_OVF) ? '0 : adc[14:0];
                            n_have[FLAG_SHORT] = 1'b1;
                        end
                    end
                    DID_BASE: begin
                        dup = n_have[FLAG_BASE];
                        if (!dup) begin
                            n_ev_aux          = adc;
                            n_ev_fine         = 1'b0;
                            n_have[FLAG_BASE] = 1'b1;
                        end
                    end
                    DID_FINE: begin
                        dup = n_have[FLAG_FINE];
                        if (!dup) begin
                            n_ev_aux          = {6'd0, adc[9:0]};
                            n_ev_fine         = 1'b1;
                            n_have[FLAG_FINE] = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                check = !fin;
            end
            OP_TRACE: begin
                n_last             = i_entry.stamp;
                n_ev_time          = i_entry.stamp;
                n_ev_mod           = w[60:56];
                n_ev_ch            = w[53:48];
                n_have[FLAG_TRACE] = 1'b1;
                check              = 1'b1;
            end
            OP_FINISH: begin
                check = 1'b1;
            end
            default: begin
            end
        endcase

        // completion / drop check on the updated event
        if (check) begin
            done = n_have[FLAG_LONG] && n_have[FLAG_SHORT] && n_have[FLAG_TRACE]
                && (n_have[FLAG_BASE] || n_have[FLAG_FINE]);
            drop = (n_have != '0) && (n_last != n_ev_time);
            if (done || drop) begin
                emit       = 1'b1;
                rec        = event_rec(done ? KIND_EVENT : KIND_DROP, n_ev_mod, n_ev_ch,
                                       n_ev_time, n_ev_long, n_ev_short, n_ev_aux,
                                       n_ev_fine);
                n_have     = '0;
                n_ev_long  = '0;
                n_ev_short = '0;
                n_ev_aux   = '0;
                n_ev_fine  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= '0;
            r_ev_mod    <= '0;
            r_ev_ch     <= '0;
            r_ev_time   <= '0;
            r_ev_long   <= '0;
            r_ev_short  <= '0;
            r_ev_aux    <= '0;
            r_ev_fine   <= 1'b0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_have     <= n_have;
                r_ev_mod   <= n_ev_mod;
                r_ev_ch    <= n_ev_ch;
                r_ev_time  <= n_ev_time;
                r_ev_long  <= n_ev_long;
                r_ev_short <= n_ev_short;
                r_ev_aux   <= n_ev_aux;
                r_ev_fine  <= n_ev_fine;
                r_last     <= n_last;
            end
            if (can_go) begin
                r_out_valid <= pop && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_out <= rec;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

### src/daq_word_event_assembler.sv
// ----------------------------------------------------------------------------
// daq_word_event_assembler: list-mode DAQ word event builder
// Turns a stream of 64-bit list-mode words into event, info, trace-sample
// and dropped-event records.
// ----------------------------------------------------------------------------
// One word is accepted per clock while the result side keeps up: the decoder
// classifies the word, updates the timestamp upper bits and the trace sample
// counter, and does the single 48x8 time-scale multiply; a two-word register
// queue then feeds the assembler, which owns the event under construction and
// the last timestamp and loads at most one result per word into the output
// register. A stall on the output side backs up into the queue and only then
// deasserts o_s_axis_tready, so each side stalls on its own. Terminators,
// type-zero words and timestamp-high loads never enter the queue. Configuration
// is written through the i_cfg_* port, always ready, and is meant to change only
// while no word is in flight; writes to indexes past the last register are
// ignored. Reset restores the register defaults (one module, sixteen channels,
// codes zero, PHA mode, scale one).
// ----------------------------------------------------------------------------
module daq_word_event_assembler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dweb_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [dweb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input word stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [63:0]                        i_s_axis_tdata,  // [63:0] data_word
    // result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [5:0] module_res, [11:6] channel, [75:12] timestamp, [91:76] long_charge,
    // [106:92] short_charge, [122:107] aux_value, [136:123] sample_a,
    // [150:137] sample_b, [164:151] sample_c, [178:165] sample_d,
    // [183:179] zero
    output logic [dweb_pkg::TDATA_W-1:0]       o_m_axis_tdata,
    output logic [2:0]                         o_m_axis_tuser   // [1:0] kind, [2] aux_is_fine
);
    import dweb_pkg::*;

    t_cfg    r_cfg;
    logic    push, q_full, q_valid, q_pop;
    t_entry  front_entry, q_entry;
    t_result result;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.module_count  <= 6'd1;
            r_cfg.channel_count <= 7'd16;
            r_cfg.high_ts_code  <= '0;
            r_cfg.sync_code     <= '0;
            r_cfg.psd_mode      <= 1'b0;
            r_cfg.ts_scale      <= 8'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MODULE_COUNT:  r_cfg.module_count  <= i_cfg_data[5:0];
                CFG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg_data[6:0];
                CFG_HIGH_TS_CODE:  r_cfg.high_ts_code  <= i_cfg_data[3:0];
                CFG_SYNC_CODE:     r_cfg.sync_code     <= i_cfg_data[3:0];
                CFG_PSD_MODE:      r_cfg.psd_mode      <= i_cfg_data[0];
                CFG_TS_SCALE:      r_cfg.ts_scale      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dweb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_word  (i_s_axis_tdata),
        .o_push  (push),
        .o_entry (front_entry),
        .i_full  (q_full)
    );

    dweb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_entry (q_entry)
    );

    dweb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psd_mode (r_cfg.psd_mode),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_entry    (q_entry),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_result   (result)
    );

    assign o_m_axis_tuser = {result.aux_is_fine, result.kind};
    assign o_m_axis_tdata = {5'd0, result.sample_d, result.sample_c, result.sample_b,
                             result.sample_a, result.aux_value,
                             result.short_charge, result.long_charge, result.timestamp,
                             result.channel, result.module_res};

endmodule

### dv/tb_daq_word_event_assembler.sv
// ----------------------------------------------------------------------------
// tb_daq_word_event_assembler: self-checking bench for the DAQ word assembler
// Streams list-mode words through the block under several register settings,
// predicts every event, info, trace-sample and dropped-event record in step
// with the input handshakes, and compares each output record field by field.
// ----------------------------------------------------------------------------
module tb_daq_word_event_assembler;
    import dweb_pkg::*;

    localparam int OPENING_WORDS = 150;        // random words under reset defaults
    localparam int PHASE_WORDS   = 300;        // random words per later setting
    localparam int SETTLE_CYCLES = 16;         // pipeline is two deep; pad well past it
    localparam int RUN_LIMIT     = 4_000_000;  // time units, several times the slowest run

    // ------------------------------------------------------------------------
    // DUT connections, inputs at known values from time zero
    // ------------------------------------------------------------------------
    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_cfg_valid     = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data      = '0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [63:0]             i_s_axis_tdata  = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]      o_m_axis_tdata;
    logic [2:0]              o_m_axis_tuser;

    daq_word_event_assembler u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    logic [63:0] words_to_send[$];   // words waiting for the driver
    t_result     records_due[$];     // predicted records, oldest first
    int          words_in_flight = 0; // queued but not yet accepted
    int          phase_words     = 0;
    int          mismatch_count  = 0;
    int          burst_left      = 1;
    int          gap_left        = 0;
    logic [27:0] prev_ts         = '0;
    logic [15:0] rcv_tick        = '0;
    logic [1:0]  rcv_mode        = 2'd0;

    // ------------------------------------------------------------------------
    // Predictor state: register copy plus the event under construction
    // ------------------------------------------------------------------------
    t_cfg        cfg_now     = '{6'd1, 7'd16, 4'd0, 4'd0, 1'b0, 8'd1};
    logic [4:0]  evt_flags   = '0;
    logic [4:0]  evt_module  = '0;
    logic [5:0]  evt_channel = '0;
    logic [63:0] evt_time    = '0;
    logic [15:0] evt_long    = '0;
    logic [14:0] evt_short   = '0;
    logic [15:0] evt_aux     = '0;
    logic        evt_fine    = 1'b0;
    logic [19:0] ts_mid      = '0;
    logic [15:0] ts_top      = '0;
    logic [63:0] latest_ts   = '0;   // most recent assembled timestamp
    logic [13:0] samples_due = '0;   // sample words still owed to the trace

    // ADC/trace time: middle bits over the 28-bit word time, scaled, 64-bit wrap
    function automatic logic [63:0] scaled_stamp(logic [31:0] lo);
        logic [63:0] t;
        t = {16'h0, ts_mid, lo[27:0]};
        return t * {56'h0, cfg_now.ts_scale};
    endfunction

    task automatic take_identity(logic [4:0] m, logic [5:0] c);
        evt_time    = latest_ts;
        evt_module  = m;
        evt_channel = c;
    endtask

    // append one predicted record
    task automatic add_record(t_result r);
        records_due.insert(records_due.size(), r);
    endtask

    // Report the event if complete, or as dropped if partial and the time moved
    task automatic close_event();
        t_result r;
        logic    done;
        done = evt_flags[FLAG_LONG] && evt_flags[FLAG_SHORT] && evt_flags[FLAG_TRACE]
            && (evt_flags[FLAG_BASE] || evt_flags[FLAG_FINE]);
        r = '0;
        if (done) begin
            r.kind = KIND_EVENT;
        end else if (evt_flags != '0 && latest_ts != evt_time) begin
            r.kind = KIND_DROP;
        end else begin
            return;
        end
        r.module_res   = {1'b0, evt_module};
        r.channel      = evt_channel;
        r.timestamp    = evt_time;
        r.long_charge  = evt_long;
        r.short_charge = evt_short;
        r.aux_value    = evt_aux;
        r.aux_is_fine  = evt_fine;
        add_record(r);
        // identity and time stay for any sample records that follow
        evt_flags = '0;
        evt_long  = '0;
        evt_short = '0;
        evt_aux   = '0;
        evt_fine  = 1'b0;
    endtask

    // Predict the records caused by one accepted word
    task automatic assemble_word(input logic [63:0] w);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [4:0]  mod;
        logic [5:0]  ch;
        logic [1:0]  did;
        logic [15:0] adc;
        logic [3:0]  code;
        logic        id_ok;
        logic        fresh;
        logic        fin;
        t_result     r;
        hi    = w[63:32];
        lo    = w[31:0];
        mod   = hi[28:24];
        did   = hi[23:22];
        ch    = hi[21:16];
        adc   = hi[15:0];
        code  = hi[23:20];
        id_ok = ({1'b0, mod} < cfg_now.module_count) && ({1'b0, ch} < cfg_now.channel_count);
        r     = '0;

        // terminator in either half: ignored, cancels pending samples
        if (hi == TERM_A || hi == TERM_B || lo == TERM_A || lo == TERM_B) begin
            samples_due = '0;
            return;
        end

        // while samples are owed, any other word is a sample word regardless of type
        if (samples_due != '0) begin
            samples_due    = samples_due - 1'b1;
            r.kind         = KIND_TRACE;
            r.module_res   = {1'b0, evt_module};
            r.channel      = evt_channel;
            r.timestamp    = evt_time;
            r.sample_a     = w[45:32];
            r.sample_b     = w[61:48];
            r.sample_c     = w[13:0];
            r.sample_d     = w[29:16];
            add_record(r);
            return;
        end

        case (hi[31:30])
            TYPE_ADC: begin
                // rejected id stores nothing but still runs the completion check
                if (id_ok) begin
                    latest_ts = scaled_stamp(lo);
                    fresh     = (evt_flags == '0);
                    fin       = 1'b0;
                    if (evt_flags[FLAG_LONG]) begin
                        if (cfg_now.psd_mode) begin
                            fin = evt_flags[FLAG_SHORT]
                                && (evt_flags[FLAG_BASE] || evt_flags[FLAG_FINE]);
                        end else begin
                            // PHA: long charge alone is enough
                            evt_flags[FLAG_SHORT] = 1'b1;
                            evt_flags[FLAG_FINE]  = 1'b1;
                            fin = 1'b1;
                        end
                    end
                    if (fresh) begin
                        take_identity(mod, ch);
                    end else if (fin) begin
                        evt_flags[FLAG_TRACE] = 1'b1;
                        close_event();
                        take_identity(mod, ch);
                    end
                    // a second item of a kind already held is dropped
                    if (!evt_flags[did]) begin
                        case (did)
                            DID_LONG:  evt_long = (adc == LONG_OVF) ? '0 : adc;
                            DID_SHORT: evt_short = (adc[14:0] == SHORT_OVF) ? '0 : adc[14:0];
                            DID_BASE: begin
                                evt_aux  = adc;
                                evt_fine = 1'b0;
                            end
                            default: begin
                                evt_aux  = {6'h0, adc[9:0]};
                                evt_fine = 1'b1;
                            end
                        endcase
                        evt_flags[did] = 1'b1;
                    end
                end
                close_event();
            end
            TYPE_INFO: begin
                // equal codes: the high timestamp load wins
                if (code == cfg_now.high_ts_code) begin
                    ts_top = hi[15:0];
                end else if (code == cfg_now.sync_code) begin
                    ts_mid    = hi[19:0];
                    latest_ts = {ts_top, hi[19:0], lo[27:0]};
                end else begin
                    r.kind       = KIND_INFO;
                    r.module_res = hi[29:24];
                    r.timestamp  = latest_ts;
                    r.aux_value  = {12'h0, code};
                    add_record(r);
                end
            end
            TYPE_TRACE: begin
                // rejected trace id: no samples owed, trace flag untouched
                if (id_ok) begin
                    samples_due = hi[15:2];
                    latest_ts   = scaled_stamp(lo);
                    take_identity(mod, ch);
                    evt_flags[FLAG_TRACE] = 1'b1;
                end
                close_event();
            end
            default: ;  // type zero is ignored
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------
    function automatic logic [63:0] adc_w(logic [4:0] m, logic [1:0] d, logic [5:0] c,
                                          logic [15:0] v, logic [31:0] lo);
        return {TYPE_ADC, 1'b0, m, d, c, v, lo};
    endfunction

    function automatic logic [63:0] info_w(logic [5:0] m, logic [3:0] code,
                                           logic [19:0] f, logic [31:0] lo);
        return {TYPE_INFO, m, code, f, lo};
    endfunction

    function automatic logic [63:0] trace_w(logic [4:0] m, logic [5:0] c,
                                            logic [13:0] n, logic [31:0] lo);
        return {TYPE_TRACE, 1'b0, m, 2'b00, c, n, 2'b00, lo};
    endfunction

    function automatic logic [63:0] term_word();
        logic [31:0] pat;
        logic [31:0] other;
        pat   = $urandom_range(0, 1) ? TERM_A : TERM_B;
        other = $urandom;
        return $urandom_range(0, 1) ? {pat, other} : {other, pat};
    endfunction

    task automatic queue_word(logic [63:0] w);
        words_to_send.insert(words_to_send.size(), w);
        words_in_flight++;
        phase_words++;
    endtask

    // Stray words: raw random, type zero, terminators, odd info and ADC words
    task automatic queue_noise();
        logic [63:0] w;
        case ($urandom_range(0, 4))
            0:       w = {$urandom, $urandom};
            1:       w = {2'b00, 30'($urandom), $urandom};
            2:       w = term_word();
            3:       w = {TYPE_INFO, 30'($urandom), $urandom};
            default: w = {TYPE_ADC, 30'($urandom), $urandom};
        endcase
        queue_word(w);
        // a random trace header may owe thousands of samples; cut it short
        if (w[63:62] == TYPE_TRACE) begin
            queue_word(term_word());
        end
    endtask

    // One well-formed event: optional time updates, ADC items in random
    // order, sometimes a duplicate, and an optional trace with samples.
    task automatic queue_event();
        logic [4:0]  mod;
        logic [5:0]  ch;
        logic [27:0] ts;
        logic [31:0] lo;
        logic [15:0] v;
        logic [1:0]  order[$];
        int          n;
        if ($urandom_range(0, 9) == 0) begin
            queue_word(info_w(6'($urandom), cfg_now.sync_code, 20'($urandom), $urandom));
        end
        if ($urandom_range(0, 19) == 0) begin
            queue_word(info_w(6'($urandom), cfg_now.high_ts_code, 20'($urandom), $urandom));
        end
        if ($urandom_range(0, 9) == 0) begin
            queue_word(info_w(6'($urandom), 4'($urandom), 20'($urandom), $urandom));
        end
        // mostly accepted ids, a few past the configured counts
        if ($urandom_range(0, 9) == 0) begin
            mod = 5'($urandom);
            ch  = 6'($urandom);
        end else begin
            mod = 5'($urandom_range(0, cfg_now.module_count - 1));
            ch  = 6'($urandom_range(0, cfg_now.channel_count - 1));
        end
        // reuse the last time now and then so equal-time items meet
        ts = ($urandom_range(0, 3) == 0) ? prev_ts : 28'($urandom);
        prev_ts = ts;
        lo = {4'($urandom), ts};
        if ($urandom_range(0, 99) < 85) order.insert($urandom_range(0, order.size()), DID_LONG);
        if ($urandom_range(0, 99) < 75) order.insert($urandom_range(0, order.size()), DID_SHORT);
        if ($urandom_range(0, 99) < 50) order.insert($urandom_range(0, order.size()), DID_BASE);
        if ($urandom_range(0, 99) < 40) order.insert($urandom_range(0, order.size()), DID_FINE);
        if ($urandom_range(0, 9) == 0) begin
            order.insert($urandom_range(0, order.size()), 2'($urandom));
        end
        foreach (order[k]) begin
            v = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom);
            queue_word(adc_w(mod, order[k], ch, v, lo));
        end
        if ($urandom_range(0, 9) < 4) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            queue_word(trace_w(mod, ch, 14'(n), lo));
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 29) == 0) begin
                    queue_word(term_word());
                end else begin
                    queue_word({$urandom, $urandom});
                end
            end
        end
    endtask

    task automatic queue_random(int count);
        phase_words = 0;
        while (phase_words < count) begin
            if ($urandom_range(0, 6) == 0) begin
                queue_noise();
            end else begin
                queue_event();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Configuration writes; the register copy follows each handshake
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MODULE_COUNT:  cfg_now.module_count  = value[5:0];
            CFG_CHANNEL_COUNT: cfg_now.channel_count = value[6:0];
            CFG_HIGH_TS_CODE:  cfg_now.high_ts_code  = value[3:0];
            CFG_SYNC_CODE:     cfg_now.sync_code     = value[3:0];
            CFG_PSD_MODE:      cfg_now.psd_mode      = value[0];
            CFG_TS_SCALE:      cfg_now.ts_scale      = value[7:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_config(int mods, int chans, int hcode, int scode, int psd, int scale);
        write_reg(CFG_MODULE_COUNT, mods);
        write_reg(CFG_CHANNEL_COUNT, chans);
        write_reg(CFG_HIGH_TS_CODE, hcode);
        write_reg(CFG_SYNC_CODE, scode);
        write_reg(CFG_PSD_MODE, psd);
        write_reg(CFG_TS_SCALE, scale);
    endtask

    // Drained: every word accepted and every record seen, then let words
    // that cause no record clear the pipeline.
    task automatic wait_idle();
        while (words_in_flight != 0 || records_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Word driver: bursts of random length, random gaps, some gapless runs.
    // Prediction happens at the accepting edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : word_driver
        logic        send;
        logic [63:0] word;
        send = i_s_axis_tvalid;
        word = i_s_axis_tdata;
        if (!i_rst_n) begin
            send = 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                assemble_word(i_s_axis_tdata);
                words_in_flight--;
                send = 1'b0;
            end
            if (!send) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (words_to_send.size() != 0) begin
                    word = words_to_send.pop_front();
                    send = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
        i_s_axis_tvalid <= send;
        i_s_axis_tdata  <= word;
    end

    // ------------------------------------------------------------------------
    // Result-side stall pattern: mode is redrawn when rcv_tick[5:0] is zero, among always
    // ready, coin flip, a fixed periodic stall and heavy backpressure.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        rcv_tick <= rcv_tick + 1'b1;
        if (rcv_tick[5:0] == 6'd0) rcv_mode <= 2'($urandom_range(0, 3));
        case (rcv_mode)
            2'd0: i_m_axis_tready <= 1'b1;
            2'd1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: i_m_axis_tready <= (rcv_tick[2:0] != 3'd5) && (rcv_tick[2:0] != 3'd6);
            default: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Record monitor
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : record_monitor
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.kind         = t_kind'(o_m_axis_tuser[1:0]);
            got.aux_is_fine  = o_m_axis_tuser[2];
            got.module_res   = o_m_axis_tdata[5:0];
            got.channel      = o_m_axis_tdata[11:6];
            got.timestamp    = o_m_axis_tdata[75:12];
            got.long_charge  = o_m_axis_tdata[91:76];
            got.short_charge = o_m_axis_tdata[106:92];
            got.aux_value    = o_m_axis_tdata[122:107];
            got.sample_a     = o_m_axis_tdata[136:123];
            got.sample_b     = o_m_axis_tdata[150:137];
            got.sample_c     = o_m_axis_tdata[164:151];
            got.sample_d     = o_m_axis_tdata[178:165];
            if (records_due.size() == 0) begin
                $display("%0t: record with none expected, expected nothing got kind %0d",
                         $time, o_m_axis_tuser[1:0]);
                mismatch_count++;
            end else begin
                want = records_due.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("module_res", want.module_res, got.module_res);
                check_field("channel", want.channel, got.channel);
                check_field("timestamp", want.timestamp, got.timestamp);
                check_field("long_charge", want.long_charge, got.long_charge);
                check_field("short_charge", want.short_charge, got.short_charge);
                check_field("aux_value", want.aux_value, got.aux_value);
                check_field("aux_is_fine", want.aux_is_fine, got.aux_is_fine);
                check_field("sample_a", want.sample_a, got.sample_a);
                check_field("sample_b", want.sample_b, got.sample_b);
                check_field("sample_c", want.sample_c, got.sample_c);
                check_field("sample_d", want.sample_d, got.sample_d);
                check_field("pad", '0, o_m_axis_tdata[183:179]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Phases
    // ------------------------------------------------------------------------
    initial begin : run_phases
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        t1 = 32'h0000_0100;
        t2 = 32'h0000_0200;
        t3 = 32'hA123_4567;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: one module, sixteen channels, both codes zero
        queue_random(OPENING_WORDS);
        wait_idle();

        // directed words, PSD mode, scale 3
        write_config(4, 8, 1, 2, 1, 3);
        queue_word(info_w(6'd0, 4'd1, 20'hFABCD, 32'h0));         // high bits, upper field ignored
        queue_word(info_w(6'd1, 4'd2, 20'hFFFFF, 32'hF000_0001)); // sync, all middle bits set
        queue_word(info_w(6'd63, 4'd9, 20'h12345, 32'h0));        // info record
        queue_word(adc_w(5'd3, DID_LONG, 6'd7, 16'hFFFF, t1));    // long overflow reads 0
        queue_word(adc_w(5'd3, DID_SHORT, 6'd7, 16'hFFFF, t1));   // short overflow reads 0
        queue_word(adc_w(5'd3, DID_BASE, 6'd7, 16'h1234, t1));
        queue_word(adc_w(5'd3, DID_FINE, 6'd7, 16'hFFFF, t1));    // completes, opens fine-only
        queue_word(adc_w(5'd0, DID_LONG, 6'd0, 16'h0000, t2));    // new time drops partial
        queue_word(adc_w(5'd31, DID_LONG, 6'd63, 16'h5555, t3));  // rejected id
        queue_word(adc_w(5'd2, DID_LONG, 6'd5, 16'h8000, t3));    // repeat long, time moved
        queue_word(adc_w(5'd2, DID_LONG, 6'd5, 16'h7FFF, t3));
        queue_word(adc_w(5'd2, DID_LONG, 6'd5, 16'h0001, t3));    // duplicate long
        queue_word(trace_w(5'd2, 6'd63, 14'd5, t3));              // rejected trace id
        queue_word(trace_w(5'd2, 6'd5, 14'd3, t3));               // three samples owed
        queue_word(64'h0123_4567_89AB_CDEF);
        queue_word(64'hFFFF_FFFE_3FFF_3FFF);                      // ADC type bits, still a sample
        queue_word({32'h1234_5678, TERM_A});                      // cancels the third sample
        queue_word(64'h0);                                        // type zero
        queue_word({TERM_B, 32'h0});
        queue_word(64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(adc_w(5'd2, DID_SHORT, 6'd5, 16'h8001, t3));
        queue_word(adc_w(5'd2, DID_BASE, 6'd5, 16'hFFFF, t3));    // full event at equal time
        queue_word(info_w(6'd5, 4'd2, 20'h0, 32'hFFFF_FFF0));     // sync to zero middle bits
        queue_word(trace_w(5'd3, 6'd7, 14'h3FFF, t1));            // largest count, then cut
        queue_word({TERM_A, 32'h0});
        wait_idle();

        // smallest counts, equal codes, PHA, largest scale
        write_config(1, 1, 5, 5, 0, 255);
        queue_random(PHASE_WORDS);
        wait_idle();

        // largest counts, extreme codes, PSD, unit scale
        write_config(32, 64, 0, 15, 1, 1);
        queue_random(PHASE_WORDS);
        wait_idle();

        repeat (4) begin
            write_config($urandom_range(1, 32), $urandom_range(1, 64), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(1, 255));
            queue_random(PHASE_WORDS);
            wait_idle();
        end

        if (mismatch_count == 0 && records_due.size() == 0) begin
            $display("[daq_word_event_assembler] OK");
        end else begin
            $display("[daq_word_event_assembler] ERROR");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #RUN_LIMIT;
        $display("[daq_word_event_assembler] ERROR");
        $finish;
    end

endmodule

### files.f
src/dweb_pkg.sv
src/dweb_front.sv
src/dweb_queue.sv
src/dweb_back.sv
src/daq_word_event_assembler.sv
dv/tb_daq_word_event_assembler.sv
